### sv/scara_ik_pkg.sv
// Shared types, widths, codes and tables of the SCARA inverse kinematics core.
`timescale 1ns / 1ps
package scara_ik_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_FRAC_DEF   = 8;
    localparam int INT_FRAC         = 24;
    localparam int ATAN_LEN         = 32;

    localparam int IN_W   = 15;
    localparam int LEN_W  = 14;
    localparam int LIM_W  = 16;
    localparam int ANG_W  = 17;
    localparam int ARM_W  = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int OP_W     = 32;
    localparam int XY_W     = 44;
    localparam int ACC_W    = 34;
    localparam int NORM_BIT = 40;
    localparam int SH_W     = 6;
    localparam int LANES    = 3;

    localparam int K_W    = 60;
    localparam int ROOT_W = K_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    localparam logic [LEN_W-1:0] INNER_RST = 14'd5600;
    localparam logic [LEN_W-1:0] OUTER_RST = 14'd4000;
    localparam logic [LIM_W-1:0] J1LIM_RST = 16'd38400;
    localparam logic [LIM_W-1:0] J2LIM_RST = 16'd43520;

    localparam logic [ARM_W-1:0] ARM_RIGHT = 2'd0;
    localparam logic [ARM_W-1:0] ARM_LEFT  = 2'd1;

    localparam logic [1:0] REG_INNER = 2'd0;
    localparam logic [1:0] REG_OUTER = 2'd1;
    localparam logic [1:0] REG_J1LIM = 2'd2;
    localparam logic [1:0] REG_J2LIM = 2'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LIMIT   = 2'd1,
        ST_UNREACH = 2'd2,
        ST_BAD_ARM = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [OP_W-1:0] n;
        logic signed [OP_W-1:0] m;
        logic                   left;
        status_t                pre;
    } sq_side_t;

    typedef struct packed {
        logic    left;
        status_t pre;
    } ck_side_t;

    localparam logic signed [ACC_W-1:0] QUARTER = 34'sd1509949440;

    // atan(2^-i), 2^-24 degree
    localparam logic signed [ACC_W-1:0] ATAN_TAB [ATAN_LEN] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115,
        34'sd57,        34'sd29,        34'sd14,        34'sd7,
        34'sd4,         34'sd2,         34'sd1,         34'sd0
    };

endpackage

### sv/scara_ik_if.sv
// Request channels of the SCARA inverse kinematics core.
`timescale 1ns / 1ps
interface scara_ik_tool_if;
    import scara_ik_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [IN_W-1:0]  tool_x;
    logic signed [IN_W-1:0]  tool_y;
    logic [ARM_W-1:0]        arm_choice;

    modport source (output valid, output tool_x, output tool_y, output arm_choice,
                    input ready);
    modport sink (input valid, input tool_x, input tool_y, input arm_choice,
                  output ready);
endinterface

interface scara_ik_joint_if;
    import scara_ik_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] joint1_angle;
    logic signed [ANG_W-1:0] joint2_angle;
    logic [1:0]              status;

    modport source (output valid, output joint1_angle, output joint2_angle, output status,
                    input ready);
    modport sink (input valid, input joint1_angle, input joint2_angle, input status,
                  output ready);
endinterface

### sv/scara_ik_front.sv
// Front pipeline: squares, triangle terms and the radicand K.
`timescale 1ns / 1ps
module scara_ik_front
    import scara_ik_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [IN_W-1:0] tool_x,
    input  logic signed [IN_W-1:0] tool_y,
    input  logic [ARM_W-1:0]       arm_choice,
    input  logic [LEN_W-1:0]       inner_len,
    input  logic [LEN_W-1:0]       outer_len,
    output logic                   out_valid,
    output logic [K_W-1:0]         k_out,
    output sq_side_t               side_out
);

    localparam int SQ_W = 2 * IN_W;
    localparam int Q_W  = SQ_W + 1;
    localparam int L2_W = 2 * LEN_W;
    localparam int QA_W = Q_W + L2_W;
    localparam int NN_W = 2 * OP_W;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [IN_W-1:0]  x1_reg, x2_reg, x3_reg, x4_reg;
    logic signed [IN_W-1:0]  y1_reg, y2_reg, y3_reg, y4_reg;
    logic [ARM_W-1:0]        arm1_reg, arm2_reg, arm3_reg;
    logic [SQ_W-1:0]         xx1_reg, yy1_reg;
    logic [L2_W-1:0]         a2_1_reg, b2_1_reg, a2_2_reg;
    logic                    zl1_reg, zl2_reg, zl3_reg;
    logic [Q_W-1:0]          q2_reg;
    logic                    qz2_reg, qz3_reg;
    logic signed [OP_W-1:0]  n2_reg, n3_reg, n4_reg;
    logic signed [OP_W-1:0]  m2_reg, m3_reg, m4_reg;
    logic [QA_W-1:0]         qa3_reg;
    logic signed [NN_W-1:0]  nn3_reg;
    logic [K_W-1:0]          k4_reg;
    logic                    left4_reg;
    status_t                 pre4_reg;

    logic signed [SQ_W-1:0]  xw, yw;
    logic [L2_W-1:0]         aw, bw;
    logic [Q_W-1:0]          q_next;
    logic signed [OP_W-1:0]  q_s, a2_s, b2_s;
    logic [QA_W-1:0]         qa_next;
    logic signed [NN_W-1:0]  nn_next, kd;
    status_t                 pre_next;

    assign xw = SQ_W'(tool_x);
    assign yw = SQ_W'(tool_y);
    assign aw = L2_W'(inner_len);
    assign bw = L2_W'(outer_len);

    assign q_next = Q_W'(xx1_reg) + Q_W'(yy1_reg);
    assign q_s    = $signed(OP_W'(q_next));
    assign a2_s   = $signed(OP_W'(a2_1_reg));
    assign b2_s   = $signed(OP_W'(b2_1_reg));

    assign qa_next = QA_W'(q2_reg) * QA_W'(a2_2_reg);
    assign nn_next = NN_W'(n2_reg) * NN_W'(n2_reg);

    assign kd = $signed(NN_W'(qa3_reg) << 2) - nn3_reg;

    always_comb
    begin
        if (arm3_reg != ARM_RIGHT && arm3_reg != ARM_LEFT)
        begin
            pre_next = ST_BAD_ARM;
        end
        else if (zl3_reg || qz3_reg || kd[NN_W-1])
        begin
            pre_next = ST_UNREACH;
        end
        else
        begin
            pre_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= tool_x;
            y1_reg   <= tool_y;
            arm1_reg <= arm_choice;
            xx1_reg  <= $unsigned(xw * xw);
            yy1_reg  <= $unsigned(yw * yw);
            a2_1_reg <= aw * aw;
            b2_1_reg <= bw * bw;
            zl1_reg  <= (inner_len == '0) || (outer_len == '0);

            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            arm2_reg <= arm1_reg;
            q2_reg   <= q_next;
            qz2_reg  <= (q_next == '0);
            n2_reg   <= q_s + a2_s - b2_s;
            m2_reg   <= q_s - a2_s - b2_s;
            a2_2_reg <= a2_1_reg;
            zl2_reg  <= zl1_reg;

            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            arm3_reg <= arm2_reg;
            qz3_reg  <= qz2_reg;
            n3_reg   <= n2_reg;
            m3_reg   <= m2_reg;
            qa3_reg  <= qa_next;
            nn3_reg  <= nn_next;
            zl3_reg  <= zl2_reg;

            x4_reg    <= x3_reg;
            y4_reg    <= y3_reg;
            n4_reg    <= n3_reg;
            m4_reg    <= m3_reg;
            left4_reg <= (arm3_reg == ARM_LEFT);
            pre4_reg  <= pre_next;
            k4_reg    <= kd[NN_W-1] ? '0 : kd[K_W-1:0];
        end
    end

    assign out_valid     = v4_reg;
    assign k_out         = k4_reg;
    assign side_out.x    = x4_reg;
    assign side_out.y    = y4_reg;
    assign side_out.n    = n4_reg;
    assign side_out.m    = m4_reg;
    assign side_out.left = left4_reg;
    assign side_out.pre  = pre4_reg;

endmodule

### sv/scara_ik_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module scara_ik_isqrt
    import scara_ik_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [K_W-1:0]    k_in,
    input  sq_side_t          side_in,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root_out,
    output sq_side_t          side_out
);

    logic [ROOT_W-1:0] v_reg;
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    sq_side_t          side_reg [ROOT_W];
    logic [K_W-1:0]    k_reg    [ROOT_W-1];
    logic [REM_W-1:0]  rem_reg  [ROOT_W-1];

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++)
        begin : g_stage
            logic              v_cur;
            logic [K_W-1:0]    k_cur;
            logic [REM_W-1:0]  rem_cur, cand, trial;
            logic [ROOT_W-1:0] root_cur;
            sq_side_t          side_cur;
            logic              ge;

            if (i == 0)
            begin : g_first
                assign v_cur    = in_valid;
                assign k_cur    = k_in;
                assign rem_cur  = '0;
                assign root_cur = '0;
                assign side_cur = side_in;
            end
            else
            begin : g_next
                assign v_cur    = v_reg[i-1];
                assign k_cur    = k_reg[i-1];
                assign rem_cur  = rem_reg[i-1];
                assign root_cur = root_reg[i-1];
                assign side_cur = side_reg[i-1];
            end

            assign cand  = {rem_cur[REM_W-3:0], k_cur[K_W-1 -: 2]};
            assign trial = {1'b0, root_cur, 2'b01};
            assign ge    = (cand >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[i] <= v_cur;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[i] <= {root_cur[ROOT_W-2:0], ge};
                    side_reg[i] <= side_cur;
                end
            end

            if (i < ROOT_W - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        k_reg[i]   <= k_cur << 2;
                        rem_reg[i] <= ge ? cand - trial : cand;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[ROOT_W-1];
    assign root_out  = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

### sv/scara_ik_cordic.sv
// Unrolled CORDIC vectoring pipeline, three atan2 lanes side by side.
`timescale 1ns / 1ps
module scara_ik_cordic
    import scara_ik_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][OP_W-1:0]  y_in,
    input  logic [LANES-1:0][OP_W-1:0]  x_in,
    input  ck_side_t                    side_in,
    output logic                        out_valid,
    output logic [LANES-1:0][ACC_W-1:0] angle_out,
    output ck_side_t                    side_out
);

    localparam int DEPTH = STEPS + 3;

    logic [DEPTH-1:0] v_reg;
    ck_side_t         side_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int d = 1; d < DEPTH; d++)
            begin
                side_reg[d] <= side_reg[d-1];
            end
        end
    end

    genvar l, s;
    generate
        for (l = 0; l < LANES; l++)
        begin : g_lane
            logic signed [OP_W-1:0]  xa_reg, ya_reg, xb_reg, yb_reg;
            logic [OP_W-1:0]         maxa_reg;
            logic                    za_reg, zb_reg, zc_reg;
            logic [SH_W-1:0]         shb_reg;
            logic signed [XY_W-1:0]  xc_reg, yc_reg;
            logic signed [ACC_W-1:0] accc_reg;

            logic signed [OP_W-1:0]  xi, yi;
            logic [OP_W-1:0]         mx, my;
            logic [SH_W-1:0]         sh_next;
            logic signed [XY_W-1:0]  xs, ys, xc_next, yc_next;
            logic signed [ACC_W-1:0] accc_next;

            logic signed [XY_W-1:0]  xs_reg  [STEPS-1];
            logic signed [XY_W-1:0]  ys_reg  [STEPS-1];
            logic signed [ACC_W-1:0] acc_reg [STEPS];
            logic [STEPS-1:0]        z_reg;

            assign xi = $signed(x_in[l]);
            assign yi = $signed(y_in[l]);
            assign mx = xi[OP_W-1] ? $unsigned(-xi) : $unsigned(xi);
            assign my = yi[OP_W-1] ? $unsigned(-yi) : $unsigned(yi);

            always_comb
            begin
                sh_next = SH_W'(NORM_BIT);
                for (int j = 0; j < OP_W; j++)
                begin
                    if (maxa_reg[j])
                    begin
                        sh_next = SH_W'(NORM_BIT - j);
                    end
                end
            end

            assign xs = XY_W'(xb_reg) <<< shb_reg;
            assign ys = XY_W'(yb_reg) <<< shb_reg;

            always_comb
            begin
                if (xs < 0)
                begin
                    if (ys >= 0)
                    begin
                        xc_next   = ys;
                        yc_next   = -xs;
                        accc_next = QUARTER;
                    end
                    else
                    begin
                        xc_next   = -ys;
                        yc_next   = xs;
                        accc_next = -QUARTER;
                    end
                end
                else
                begin
                    xc_next   = xs;
                    yc_next   = ys;
                    accc_next = '0;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    xa_reg   <= xi;
                    ya_reg   <= yi;
                    maxa_reg <= (mx > my) ? mx : my;
                    za_reg   <= (xi == '0) && (yi == '0);

                    xb_reg  <= xa_reg;
                    yb_reg  <= ya_reg;
                    shb_reg <= sh_next;
                    zb_reg  <= za_reg;

                    xc_reg   <= xc_next;
                    yc_reg   <= yc_next;
                    accc_reg <= accc_next;
                    zc_reg   <= zb_reg;
                end
            end

            for (s = 0; s < STEPS; s++)
            begin : g_step
                logic signed [XY_W-1:0]  x_cur, y_cur, dx, dy;
                logic signed [ACC_W-1:0] acc_cur;
                logic                    z_cur, neg;

                if (s == 0)
                begin : g_first
                    assign x_cur   = xc_reg;
                    assign y_cur   = yc_reg;
                    assign acc_cur = accc_reg;
                    assign z_cur   = zc_reg;
                end
                else
                begin : g_next
                    assign x_cur   = xs_reg[s-1];
                    assign y_cur   = ys_reg[s-1];
                    assign acc_cur = acc_reg[s-1];
                    assign z_cur   = z_reg[s-1];
                end

                assign dx  = y_cur >>> s;
                assign dy  = x_cur >>> s;
                assign neg = (y_cur > 0);

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        acc_reg[s] <= neg ? acc_cur + ATAN_TAB[s] : acc_cur - ATAN_TAB[s];
                        z_reg[s]   <= z_cur;
                    end
                end

                if (s < STEPS - 1)
                begin : g_carry
                    always_ff @(posedge clk)
                    begin
                        if (en)
                        begin
                            xs_reg[s] <= neg ? x_cur + dx : x_cur - dx;
                            ys_reg[s] <= neg ? y_cur - dy : y_cur + dy;
                        end
                    end
                end
            end

            assign angle_out[l] = z_reg[STEPS-1] ? '0 : acc_reg[STEPS-1];
        end
    endgenerate

    assign out_valid = v_reg[DEPTH-1];
    assign side_out  = side_reg[DEPTH-1];

endmodule

### sv/scara_ik_back.sv
// Back pipeline: joint sums, rounding, wrapping and limit checks.
`timescale 1ns / 1ps
module scara_ik_back
    import scara_ik_pkg::*;
#(
    parameter int ANGLE_FRACTION_BITS = ANGLE_FRAC_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [ACC_W-1:0] beta,
    input  logic signed [ACC_W-1:0] alpha,
    input  logic signed [ACC_W-1:0] gamma,
    input  ck_side_t                side_in,
    input  logic [LIM_W-1:0]        joint1_limit,
    input  logic [LIM_W-1:0]        joint2_limit,
    output logic                    out_valid,
    output logic [ANG_W-1:0]        joint1_angle,
    output logic [ANG_W-1:0]        joint2_angle,
    output status_t                 status
);

    localparam int SHIFT = INT_FRAC - ANGLE_FRACTION_BITS;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(180 * (2 ** ANGLE_FRACTION_BITS));
    localparam logic signed [ACC_W-1:0] RND  = ACC_W'(2 ** (SHIFT - 1));

    function automatic logic signed [ACC_W-1:0] wrap(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = v;
        if (v >= HALF)
        begin
            r = v - (HALF <<< 1);
        end
        else if (v < -HALF)
        begin
            r = v + (HALF <<< 1);
        end
        return r;
    endfunction

    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [ACC_W-1:0] r1_reg, rg1_reg, j1_2_reg, j2_2_reg;
    logic                    left1_reg;
    status_t                 pre1_reg, pre2_reg, st3_reg;
    logic [ANG_W-1:0]        j1_3_reg, j2_3_reg;

    logic signed [ACC_W-1:0] sum, g2;
    logic [ACC_W-1:0]        a1, a2;
    logic                    over;

    assign sum  = side_in.left ? beta + alpha : beta - alpha;
    assign g2   = left1_reg ? -rg1_reg : rg1_reg;
    assign a1   = j1_2_reg[ACC_W-1] ? $unsigned(-j1_2_reg) : $unsigned(j1_2_reg);
    assign a2   = j2_2_reg[ACC_W-1] ? $unsigned(-j2_2_reg) : $unsigned(j2_2_reg);
    assign over = (a1 > ACC_W'(joint1_limit)) || (a2 > ACC_W'(joint2_limit));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg    <= (sum + RND) >>> SHIFT;
            rg1_reg   <= (gamma + RND) >>> SHIFT;
            left1_reg <= side_in.left;
            pre1_reg  <= side_in.pre;

            j1_2_reg <= wrap(r1_reg);
            j2_2_reg <= wrap(g2);
            pre2_reg <= pre1_reg;

            if (pre2_reg != ST_OK)
            begin
                j1_3_reg <= '0;
                j2_3_reg <= '0;
                st3_reg  <= pre2_reg;
            end
            else
            begin
                j1_3_reg <= j1_2_reg[ANG_W-1:0];
                j2_3_reg <= j2_2_reg[ANG_W-1:0];
                st3_reg  <= over ? ST_LIMIT : ST_OK;
            end
        end
    end

    assign out_valid    = v3_reg;
    assign joint1_angle = j1_3_reg;
    assign joint2_angle = j2_3_reg;
    assign status       = st3_reg;

endmodule

### sv/scara_inverse_kinematics_core.sv
// Top level of the SCARA inverse kinematics core: registers, pipeline and output buffer.
//
//   channel   dir   handshake      payload
//   tool      in    valid/ready    tool_x, tool_y, arm_choice
//   joint     out   valid/ready    joint1_angle, joint2_angle, status
//   apb       in    psel/penable   4 registers at byte addresses 0, 4, 8, 12
//
// One request per cycle while the pipeline runs; the path holds the front stages, the 30
// square root stages, the unrolled CORDIC stages and the back stages. Reset restores the
// register defaults and empties the pipeline. The pipeline halts as a whole only while
// the output buffer holds two results; a stall drops nothing.
`timescale 1ns / 1ps
module scara_inverse_kinematics_core
    import scara_ik_pkg::*;
#(
    parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRACTION_BITS = ANGLE_FRAC_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    scara_ik_tool_if.sink     tool,
    scara_ik_joint_if.source  joint,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [LEN_W-1:0] inner_reg, outer_reg;
    logic [LIM_W-1:0] j1lim_reg, j2lim_reg;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= INNER_RST;
            outer_reg <= OUTER_RST;
            j1lim_reg <= J1LIM_RST;
            j2lim_reg <= J2LIM_RST;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                REG_INNER: inner_reg <= pwdata[LEN_W-1:0];
                REG_OUTER: outer_reg <= pwdata[LEN_W-1:0];
                REG_J1LIM: j1lim_reg <= pwdata[LIM_W-1:0];
                REG_J2LIM: j2lim_reg <= pwdata[LIM_W-1:0];
                default:   inner_reg <= inner_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_INNER: prdata = DATA_W'(inner_reg);
            REG_OUTER: prdata = DATA_W'(outer_reg);
            REG_J1LIM: prdata = DATA_W'(j1lim_reg);
            REG_J2LIM: prdata = DATA_W'(j2lim_reg);
            default:   prdata = '0;
        endcase
    end

    logic                        en;
    logic                        f_valid, q_valid, c_valid, b_valid;
    logic [K_W-1:0]              f_k;
    sq_side_t                    f_side, q_side;
    logic [ROOT_W-1:0]           q_root;
    logic [LANES-1:0][OP_W-1:0]  c_y, c_x;
    logic [LANES-1:0][ACC_W-1:0] c_ang;
    ck_side_t                    c_side_in, c_side;
    logic [ANG_W-1:0]            b_j1, b_j2;
    status_t                     b_st;

    logic                        out_valid_reg, skid_valid_reg;
    logic [ANG_W-1:0]            out_j1_reg, out_j2_reg, skid_j1_reg, skid_j2_reg;
    status_t                     out_st_reg, skid_st_reg;

    assign en         = !skid_valid_reg;
    assign tool.ready = en;

    scara_ik_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (tool.valid),
        .tool_x     (tool.tool_x),
        .tool_y     (tool.tool_y),
        .arm_choice (tool.arm_choice),
        .inner_len  (inner_reg),
        .outer_len  (outer_reg),
        .out_valid  (f_valid),
        .k_out      (f_k),
        .side_out   (f_side)
    );

    scara_ik_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .k_in      (f_k),
        .side_in   (f_side),
        .out_valid (q_valid),
        .root_out  (q_root),
        .side_out  (q_side)
    );

    assign c_y[0] = $unsigned(OP_W'(q_side.y));
    assign c_x[0] = $unsigned(OP_W'(q_side.x));
    assign c_y[1] = OP_W'(q_root);
    assign c_x[1] = $unsigned(q_side.n);
    assign c_y[2] = OP_W'(q_root);
    assign c_x[2] = $unsigned(q_side.m);
    assign c_side_in.left = q_side.left;
    assign c_side_in.pre  = q_side.pre;

    scara_ik_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .y_in      (c_y),
        .x_in      (c_x),
        .side_in   (c_side_in),
        .out_valid (c_valid),
        .angle_out (c_ang),
        .side_out  (c_side)
    );

    scara_ik_back #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (c_valid),
        .beta         ($signed(c_ang[0])),
        .alpha        ($signed(c_ang[1])),
        .gamma        ($signed(c_ang[2])),
        .side_in      (c_side),
        .joint1_limit (j1lim_reg),
        .joint2_limit (j2lim_reg),
        .out_valid    (b_valid),
        .joint1_angle (b_j1),
        .joint2_angle (b_j2),
        .status       (b_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !joint.ready)
        begin
            if (en && b_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !joint.ready)
        begin
            if (en && b_valid)
            begin
                skid_j1_reg <= b_j1;
                skid_j2_reg <= b_j2;
                skid_st_reg <= b_st;
            end
        end
        else if (skid_valid_reg)
        begin
            out_j1_reg <= skid_j1_reg;
            out_j2_reg <= skid_j2_reg;
            out_st_reg <= skid_st_reg;
        end
        else
        begin
            out_j1_reg <= b_j1;
            out_j2_reg <= b_j2;
            out_st_reg <= b_st;
        end
    end

    assign joint.valid        = out_valid_reg;
    assign joint.joint1_angle = $signed(out_j1_reg);
    assign joint.joint2_angle = $signed(out_j2_reg);
    assign joint.status       = out_st_reg;

endmodule

### tb/sv/tb_scara_inverse_kinematics_core.sv
// Testbench of the SCARA inverse kinematics core: random and directed points, predicted.
`timescale 1ns / 1ps
module tb_scara_inverse_kinematics_core;
    import scara_ik_pkg::*;

    localparam int  STEPS     = CORDIC_STEPS_DEF;
    localparam int  AFRAC     = ANGLE_FRAC_DEF;
    localparam int  LATENCY   = 41 + STEPS;
    localparam int  IDLE_MAX  = 20000;
    localparam int  HOLD_LEN  = 400;

    localparam longint ATAN_FX [32] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717, 15018523, 7509720,
        3754917, 1877466, 938734, 469367, 234684, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [ANG_W-1:0] j1;
        logic signed [ANG_W-1:0] j2;
        status_t                 st;
    } joints_t;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    scara_ik_tool_if  tool ();
    scara_ik_joint_if joint ();

    scara_inverse_kinematics_core u_dut (
        .clk(clk), .rst_n(rst_n), .tool(tool.sink), .joint(joint.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    joints_t        joints_due [$];
    longint         len_inner, len_outer, lim_j1, lim_j2;
    int             errors = 0;
    int             points_sent = 0;
    int             joints_seen = 0;
    bit             steady = 0;
    bit             hold_req = 0;

    always #5 clk = ~clk;

    function automatic longint mag64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint isqrt_fx(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint atan2_fx(longint y, longint x);
        longint acc, t, dx, dy, big;
        acc = 0;
        if (x == 0 && y == 0)
            return 0;
        big = 64'sd1 << 40;
        while ((mag64(x) > mag64(y) ? mag64(x) : mag64(y)) < big)
        begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                acc = 64'sd1509949440;
            end
            else
            begin
                x = -y;
                y = t;
                acc = -64'sd1509949440;
            end
        end
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                acc += ATAN_FX[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                acc -= ATAN_FX[i];
            end
        end
        return acc;
    endfunction

    function automatic longint to_out_units(longint a);
        return (a + (64'sd1 << (INT_FRAC - AFRAC - 1))) >>> (INT_FRAC - AFRAC);
    endfunction

    function automatic longint wrap_half_turn(longint v);
        longint h;
        h = 180 * (64'sd1 << AFRAC);
        if (v >= h)
            v -= 2 * h;
        else if (v < -h)
            v += 2 * h;
        return v;
    endfunction

    function automatic joints_t solve_joints(int x, int y, logic [ARM_W-1:0] arm);
        joints_t r;
        longint a, b, q, a2, b2, n, m, k, s, beta, alpha, gamma, j1, j2;
        j1 = 0;
        j2 = 0;
        if (arm != ARM_RIGHT && arm != ARM_LEFT)
            r.st = ST_BAD_ARM;
        else
        begin
            a = len_inner;
            b = len_outer;
            q = longint'(x) * x + longint'(y) * y;
            a2 = a * a;
            b2 = b * b;
            n = q + a2 - b2;
            m = q - a2 - b2;
            k = 4 * q * a2 - n * n;
            if (a == 0 || b == 0 || q == 0 || k < 0)
                r.st = ST_UNREACH;
            else
            begin
                s = isqrt_fx(longint'(k));
                beta = atan2_fx(y, x);
                alpha = atan2_fx(s, n);
                gamma = to_out_units(atan2_fx(s, m));
                if (arm == ARM_LEFT)
                begin
                    j1 = wrap_half_turn(to_out_units(beta + alpha));
                    j2 = wrap_half_turn(-gamma);
                end
                else
                begin
                    j1 = wrap_half_turn(to_out_units(beta - alpha));
                    j2 = wrap_half_turn(gamma);
                end
                r.st = (mag64(j1) > lim_j1 || mag64(j2) > lim_j2) ? ST_LIMIT : ST_OK;
            end
        end
        r.j1 = j1[ANG_W-1:0];
        r.j2 = j2[ANG_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_INNER: len_inner = value[LEN_W-1:0];
            REG_OUTER: len_outer = value[LEN_W-1:0];
            REG_J1LIM: lim_j1 = value[LIM_W-1:0];
            default:   lim_j2 = value[LIM_W-1:0];
        endcase
    endtask

    task automatic set_arm(int a, int b, int l1, int l2);
        write_reg(REG_INNER, a);
        write_reg(REG_OUTER, b);
        write_reg(REG_J1LIM, l1);
        write_reg(REG_J2LIM, l2);
    endtask

    task automatic drain;
        wait (joints_due.size() == 0);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic send_point(int x, int y, logic [ARM_W-1:0] arm);
        int gap, r;
        gap = 0;
        if (!steady)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(10, 40);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            tool.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        tool.valid <= 1;
        tool.tool_x <= x[IN_W-1:0];
        tool.tool_y <= y[IN_W-1:0];
        tool.arm_choice <= arm;
        do @(posedge clk); while (!tool.ready);
        joints_due.push_back(solve_joints(x, y, arm));
        points_sent++;
        @(negedge clk);
    endtask

    task automatic park_sender;
        tool.valid <= 0;
        @(negedge clk);
    endtask

    task automatic send_random(int count, int good_pct);
        int x, y, lim, rmin, rmax;
        longint q;
        logic [ARM_W-1:0] arm;
        for (int i = 0; i < count; i++)
        begin
            arm = ($urandom_range(0, 9) == 0) ? ARM_W'($urandom_range(2, 3))
                                              : ARM_W'($urandom_range(0, 1));
            x = $urandom_range(0, 32767) - 16384;
            y = $urandom_range(0, 32767) - 16384;
            if ($urandom_range(0, 99) < good_pct)
            begin
                rmax = int'(len_inner + len_outer);
                rmin = int'(len_inner > len_outer ? len_inner - len_outer
                                                  : len_outer - len_inner);
                lim = rmax > 16383 ? 16383 : rmax;
                for (int t = 0; t < 30; t++)
                begin
                    x = $urandom_range(0, 2 * lim) - lim;
                    y = $urandom_range(0, 2 * lim) - lim;
                    q = longint'(x) * x + longint'(y) * y;
                    if (q > 0 && q >= longint'(rmin) * rmin && q <= longint'(rmax) * rmax)
                        break;
                end
            end
            send_point(x, y, arm);
        end
        park_sender();
    endtask

    task automatic test_directed;
        send_point(0, 0, ARM_RIGHT);
        send_point(9600, 0, ARM_RIGHT);
        send_point(1600, 0, ARM_LEFT);
        send_point(-9000, 0, ARM_RIGHT);
        send_point(-9000, 0, ARM_LEFT);
        send_point(-6000, -1, ARM_RIGHT);
        send_point(0, 7000, ARM_LEFT);
        send_point(0, -7000, ARM_RIGHT);
        send_point(16383, 16383, ARM_RIGHT);
        send_point(-16384, -16384, ARM_LEFT);
        send_point(16383, 0, ARM_RIGHT);
        send_point(-16384, 0, ARM_LEFT);
        send_point(0, -16384, ARM_RIGHT);
        send_point(5000, 5000, 2'd2);
        send_point(0, 0, 2'd3);
        send_point(-4000, 6000, ARM_LEFT);
        send_point(-4000, -6000, ARM_RIGHT);
        send_point(100, 0, ARM_RIGHT);
        park_sender();
        drain();
    endtask

    task automatic test_default_links;
        send_random(90, 80);
        drain();
    endtask

    task automatic test_tight_limits;
        set_arm(5600, 4000, 0, 0);
        send_random(30, 90);
        drain();
        set_arm(5600, 4000, 46080, 46080);
        send_random(30, 90);
        drain();
    endtask

    task automatic test_link_extremes;
        set_arm(1, 1, 20000, 30000);
        send_point(1, 0, ARM_RIGHT);
        send_point(1, 1, ARM_LEFT);
        send_point(0, -2, ARM_RIGHT);
        send_point(2, 0, ARM_LEFT);
        send_random(20, 50);
        drain();
        set_arm(16383, 16383, 38400, 43520);
        send_random(50, 85);
        drain();
        set_arm(16383, 1, 46080, 46080);
        send_random(30, 85);
        drain();
        set_arm(3000, 9000, 30000, 40000);
        send_random(50, 85);
        drain();
    endtask

    task automatic test_backpressure;
        set_arm(5600, 4000, 38400, 43520);
        steady = 1;
        hold_req = 1;
        send_random(100, 80);
        steady = 0;
        drain();
    endtask

    initial
    begin
        joint.ready = 0;
        forever
        begin
            int r, len;
            @(negedge clk);
            if (hold_req)
            begin
                joint.ready <= 0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_req = 0;
            end
            else if (steady)
                joint.ready <= 1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    len = (r < 2) ? $urandom_range(20, 60) : $urandom_range(1, 3);
                    joint.ready <= 0;
                    repeat (len - 1) @(negedge clk);
                end
                else
                    joint.ready <= 1;
            end
        end
    end

    always @(posedge clk)
    begin
        joints_t e;
        if (rst_n && joint.valid && joint.ready)
        begin
            joints_seen++;
            if (joints_due.size() == 0)
                report_mismatch("result with nothing outstanding");
            else
            begin
                e = joints_due.pop_front();
                if (joint.joint1_angle !== e.j1)
                    report_mismatch($sformatf("joint1 %0d, want %0d",
                                              joint.joint1_angle, e.j1));
                if (joint.joint2_angle !== e.j2)
                    report_mismatch($sformatf("joint2 %0d, want %0d",
                                              joint.joint2_angle, e.j2));
                if (joint.status !== e.st)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              joint.status, e.st));
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((tool.valid && tool.ready) || (joint.valid && joint.ready) || psel)
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_MAX)
            begin
                $display("Watchdog expired with %0d results outstanding", joints_due.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        tool.valid = 0;
        tool.tool_x = '0;
        tool.tool_y = '0;
        tool.arm_choice = '0;
        len_inner = INNER_RST;
        len_outer = OUTER_RST;
        lim_j1 = J1LIM_RST;
        lim_j2 = J2LIM_RST;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_directed();
        test_default_links();
        test_tight_limits();
        test_link_extremes();
        test_backpressure();
        drain();
        if (joints_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", joints_due.size()));
        $display("Sent %0d tool points over several link and limit settings, %0d checked",
                 points_sent, joints_seen);
        $display("Covered unreachable, bad arm, limit, half-turn and output stall cases");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
sv/scara_ik_pkg.sv
sv/scara_ik_if.sv
sv/scara_ik_front.sv
sv/scara_ik_isqrt.sv
sv/scara_ik_cordic.sv
sv/scara_ik_back.sv
sv/scara_inverse_kinematics_core.sv
tb/sv/tb_scara_inverse_kinematics_core.sv
